// ----- rtl/rpr_pkg.sv -----
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types, constants and helpers for the relative polar point resolver.
// ----------------------------------------------------------------------------
package rpr_pkg;

  // Coordinate mode carried in the input tuser
  typedef enum logic [1:0] {
    MODE_ABS     = 2'd0,
    MODE_REL     = 2'd1,
    MODE_POLAR   = 2'd2,
    MODE_INVALID = 2'd3
  } coord_mode_t;

  // Extra fraction bits kept through the rotator
  localparam int GUARD_BITS = 8;
  // Rotator datapath widths: vector components and residual phase
  localparam int XW = 32 + GUARD_BITS + 2;
  localparam int ZW = 34;

  // CORDIC gain correction, 0.6072529350 in Q31
  localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

  // Degrees in one turn and the rounding half for the phase conversion
  localparam logic [9:0] DEG_TURN  = 10'd360;
  localparam logic [9:0] HALF_TURN = 10'd180;

  // 2^32 = 360 * PHASE_Q0 + PHASE_R0
  localparam logic [31:0] PHASE_Q0 = 32'((64'd1 << 32) / 64'd360);
  localparam logic [31:0] PHASE_R0 = 32'((64'd1 << 32) % 64'd360);

  // Reciprocal of 360 for 33-bit dividends
  localparam int          PHASE_SHIFT = 33;
  localparam int          QW          = 25;
  localparam logic [QW-1:0] RECIP_360 = QW'((64'd1 << PHASE_SHIFT) / 64'd360);

  // Arctangent of 2^-i, with one turn = 2^32
  localparam int ATAN_ENTRIES = 30;
  localparam logic [31:0] ATAN_PHASE [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // Side information that travels alongside the rotator
  typedef struct packed {
    logic              pv;      // point resolved
    logic              polar;   // add the rotated offset to the base
    logic              fold;    // angle folded by half a turn
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
  } rpr_side_t;

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] res;
    if (v > 35'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/rpr_front.sv -----
// ----------------------------------------------------------------------------
// rpr_front
// Mode decode, angle reduction to a 32-bit phase and rotator start vector.
// Seven register stages, all advancing on en.
// ----------------------------------------------------------------------------
module rpr_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  rpr_pkg::coord_mode_t        coord_mode,
  input  logic [31:0]                 first_val,
  input  logic [31:0]                 second_val,
  input  logic                        ref_present,
  input  logic [31:0]                 ref_x,
  input  logic [31:0]                 ref_y,
  output logic                        out_vld,
  output rpr_pkg::rpr_side_t          out_side,
  output logic signed [rpr_pkg::XW-1:0] out_x,
  output logic signed [rpr_pkg::ZW-1:0] out_z
);
  import rpr_pkg::*;

  // Whole degrees part of the angle and reciprocal for its mod 360
  localparam int HW  = 32 - FRAC_BITS;
  localparam int S1  = HW + 9;
  localparam int P1W = HW + S1;
  localparam logic [P1W-1:0] M1   = P1W'((64'd1 << S1) / 64'd360);
  // 2^HW mod 360, to correct the remainder of a negative angle
  localparam logic [8:0]     CMOD = 9'((64'd1 << HW) % 64'd360);
  localparam logic [8:0]     CADD = 9'(DEG_TURN) - CMOD;

  rpr_side_t side_in;
  logic [HW-1:0] deg_u;

  // Stage registers
  logic                 s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld;
  rpr_side_t            s1_side, s2_side, s3_side, s4_side, s5_side, s6_side, s7_side;
  logic [HW-1:0]        s1_u;
  logic                 s1_neg, s2_neg;
  logic [FRAC_BITS-1:0] s1_low, s2_low, s3_low;
  logic [P1W-1:0]       s1_prod;
  logic signed [63:0]   s1_prodk;
  logic [9:0]           s2_rem;
  logic signed [XW-1:0] s2_x0, s3_x0, s4_x0, s5_x0, s6_x0, s7_x0;
  logic [8:0]           s3_m;
  logic [32:0]          s4_v, s5_v;
  logic [31:0]          s4_mq, s5_mq, s6_mq;
  logic [57:0]          s5_prod;
  logic [QW-1:0]        s6_q;
  logic [9:0]           s6_rem;
  logic signed [ZW-1:0] s7_z;

  // Combinational helpers between stages
  logic [HW-1:0] q1;
  logic [8:0]    m0;
  logic [8:0]    m_fix;
  logic [QW-1:0] q2;
  logic [31:0]   phase;
  logic          fold;
  rpr_side_t     side_f;

  assign deg_u = second_val[31:FRAC_BITS];

  // Mode decode: base point and flags
  always_comb begin
    side_in = '0;
    unique case (coord_mode)
      MODE_ABS: begin
        side_in.pv     = 1'b1;
        side_in.base_x = first_val;
        side_in.base_y = second_val;
      end
      MODE_REL: begin
        if (ref_present) begin
          side_in.pv     = 1'b1;
          side_in.base_x = sat32(35'($signed(ref_x)) + 35'($signed(first_val)));
          side_in.base_y = sat32(35'($signed(ref_y)) + 35'($signed(second_val)));
        end
      end
      MODE_POLAR: begin
        if (ref_present) begin
          side_in.pv     = 1'b1;
          side_in.polar  = 1'b1;
          side_in.base_x = ref_x;
          side_in.base_y = ref_y;
        end
      end
      MODE_INVALID: begin
      end
    endcase
  end

  // Remainder steps and phase assembly
  always_comb begin
    q1 = HW'(s1_prod >> S1);
    m0 = (s2_rem >= DEG_TURN) ? 9'(s2_rem - DEG_TURN) : 9'(s2_rem);
    if (s2_neg) begin
      m_fix = (m0 >= CMOD) ? (m0 - CMOD) : (m0 + CADD);
    end else begin
      m_fix = m0;
    end
    q2    = QW'(s5_prod >> PHASE_SHIFT);
    phase = s6_mq + 32'(s6_q) + 32'(s6_rem >= DEG_TURN);
    fold  = phase[31] ^ phase[30];
    side_f      = s6_side;
    side_f.fold = fold;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: reciprocal product of whole degrees, gain product of radius
      s1_side  <= side_in;
      s1_u     <= deg_u;
      s1_neg   <= second_val[31];
      s1_low   <= second_val[FRAC_BITS-1:0];
      s1_prod  <= P1W'(deg_u) * M1;
      s1_prodk <= $signed(first_val) * GAIN_Q31;
      // stage 2: raw remainder in [0, 720), start vector
      s2_side  <= s1_side;
      s2_neg   <= s1_neg;
      s2_low   <= s1_low;
      s2_rem   <= 10'(P1W'(s1_u) - P1W'(q1) * P1W'(DEG_TURN));
      s2_x0    <= XW'(s1_prodk >>> (31 - GUARD_BITS));
      // stage 3: whole degrees mod 360
      s3_side  <= s2_side;
      s3_low   <= s2_low;
      s3_m     <= m_fix;
      s3_x0    <= s2_x0;
      // stage 4: split the phase division into m*Q0 and a 33-bit remainder part
      s4_side  <= s3_side;
      s4_v     <= 33'(s3_m) * 33'(PHASE_R0) + (33'(s3_low) << (32 - FRAC_BITS))
                  + 33'(HALF_TURN);
      s4_mq    <= 32'(s3_m) * PHASE_Q0;
      s4_x0    <= s3_x0;
      // stage 5: reciprocal product
      s5_side  <= s4_side;
      s5_v     <= s4_v;
      s5_mq    <= s4_mq;
      s5_prod  <= 58'(s4_v) * 58'(RECIP_360);
      s5_x0    <= s4_x0;
      // stage 6: quotient estimate and its remainder
      s6_side  <= s5_side;
      s6_mq    <= s5_mq;
      s6_q     <= q2;
      s6_rem   <= 10'(s5_v - 33'(q2) * 33'(DEG_TURN));
      s6_x0    <= s5_x0;
      // stage 7: phase, half-turn fold into the right half plane
      s7_side      <= side_f;
      s7_z         <= ZW'($signed({phase[31] ^ fold, phase[30:0]}));
      s7_x0        <= s6_x0;
    end
  end

  assign out_vld  = s7_vld;
  assign out_side = s7_side;
  assign out_x    = s7_x0;
  assign out_z    = s7_z;

endmodule

// ----- rtl/rpr_cell.sv -----
// ----------------------------------------------------------------------------
// rpr_cell
// One CORDIC rotation step with its side information, registered on en.
// ----------------------------------------------------------------------------
module rpr_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  rpr_pkg::rpr_side_t            in_side,
  input  logic signed [rpr_pkg::XW-1:0] in_x,
  input  logic signed [rpr_pkg::XW-1:0] in_y,
  input  logic signed [rpr_pkg::ZW-1:0] in_z,
  output logic                          out_vld,
  output rpr_pkg::rpr_side_t            out_side,
  output logic signed [rpr_pkg::XW-1:0] out_x,
  output logic signed [rpr_pkg::XW-1:0] out_y,
  output logic signed [rpr_pkg::ZW-1:0] out_z
);
  import rpr_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_PHASE[IDX]);

  logic signed [XW-1:0] xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z_next;

  // Rotate towards zero residual phase
  always_comb begin
    xs = in_x >>> IDX;
    ys = in_y >>> IDX;
    if (!in_z[ZW-1]) begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ANGLE;
    end else begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
    end
  end

endmodule

// ----- rtl/rpr_back.sv -----
// ----------------------------------------------------------------------------
// rpr_back
// Rounds the rotated vector, adds it to the base point with saturation (polar
// only) and holds results in an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module rpr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  rpr_pkg::rpr_side_t            in_side,
  input  logic signed [rpr_pkg::XW-1:0] in_x,
  input  logic signed [rpr_pkg::XW-1:0] in_y,
  output logic                          en,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          point_valid,
  output logic [31:0]                   point_x,
  output logic [31:0]                   point_y
);
  import rpr_pkg::*;

  localparam int DW = XW - GUARD_BITS;
  localparam logic signed [XW-1:0] RND = XW'(1) <<< (GUARD_BITS - 1);

  logic signed [XW-1:0] rx, ry;
  logic signed [DW-1:0] dx, dy;

  logic                 b1_vld;
  rpr_side_t            b1_side;
  logic signed [DW-1:0] b1_dx, b1_dy;

  logic        res_pv;
  logic [31:0] res_x, res_y;

  logic        skid_full;
  logic        sk_pv;
  logic [31:0] sk_x, sk_y;
  logic        take, arrive;

  // Round away the guard bits, undo the half-turn fold
  always_comb begin
    rx = in_x + RND;
    ry = in_y + RND;
    dx = DW'(rx >>> GUARD_BITS);
    dy = DW'(ry >>> GUARD_BITS);
    if (in_side.fold) begin
      dx = -dx;
      dy = -dy;
    end
  end

  // Offset onto the reference point
  always_comb begin
    res_pv = b1_side.pv;
    if (b1_side.polar) begin
      res_x = sat32(35'(b1_side.base_x) + 35'(b1_dx));
      res_y = sat32(35'(b1_side.base_y) + 35'(b1_dy));
    end else begin
      res_x = b1_side.base_x;
      res_y = b1_side.base_y;
    end
  end

  assign en     = !skid_full;
  assign take   = out_valid && out_ready;
  assign arrive = en && b1_vld;

  // Rounding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
    end else if (en) begin
      b1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_side <= in_side;
      b1_dx   <= dx;
      b1_dy   <= dy;
    end
  end

  // Output register and skid entry control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (arrive) begin
      if (out_valid && !take) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        point_valid <= sk_pv;
        point_x     <= sk_x;
        point_y     <= sk_y;
      end
    end else if (arrive) begin
      if (out_valid && !take) begin
        sk_pv <= res_pv;
        sk_x  <= res_x;
        sk_y  <= res_y;
      end else begin
        point_valid <= res_pv;
        point_x     <= res_x;
        point_y     <= res_y;
      end
    end
  end

endmodule

// ----- rtl/relative_polar_point_resolver.sv -----
// ----------------------------------------------------------------------------
// relative_polar_point_resolver
// Resolves absolute, relative cartesian or relative polar coordinates into a
// point, using a pipelined CORDIC for the polar offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transaction per coordinate item. tdata holds first_val,
//   second_val, ref_x and ref_y; tuser holds coord_mode and ref_present.
//   Output stream: one transaction per input item, carrying point_x and
//   point_y in tdata and point_valid in tuser (0 for an invalid mode or a
//   relative mode without reference; the point then reads as zero).
//   Throughput: one item per cycle while the output is not stalled. The path
//   from acceptance to m_axis_tvalid runs through seven stages of angle
//   reduction and phase conversion, one cell per CORDIC stage (capped at
//   ATAN_ENTRIES), one rounding stage and the output register.
//   When the receiver stalls, the output register holds its transaction and
//   one further result lands in a skid entry; s_axis_tready then drops until
//   the skid entry drains, and the whole pipeline holds in place.
//   Reset empties the pipeline and the output; there is no other state and
//   items are ready to be accepted in the cycle after reset is released.
// ----------------------------------------------------------------------------
module relative_polar_point_resolver #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // first_val, second_val, ref_x, ref_y
  input  logic [2:0]   s_axis_tuser,  // coord_mode[1:0], ref_present
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // point_x, point_y
  output logic [0:0]   m_axis_tuser   // point_valid
);
  import rpr_pkg::*;

  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic pipe_en;

  // Rotator chain
  logic                 c_vld  [NS+1];
  rpr_side_t            c_side [NS+1];
  logic signed [XW-1:0] c_x    [NS+1];
  logic signed [XW-1:0] c_y    [NS+1];
  logic signed [ZW-1:0] c_z    [NS+1];

  logic        res_pv;
  logic [31:0] res_x, res_y;

  // Decode, angle reduction and start vector
  rpr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (pipe_en),
    .in_vld      (s_axis_tvalid),
    .coord_mode  (coord_mode_t'(s_axis_tuser[1:0])),
    .first_val   (s_axis_tdata[31:0]),
    .second_val  (s_axis_tdata[63:32]),
    .ref_present (s_axis_tuser[2]),
    .ref_x       (s_axis_tdata[95:64]),
    .ref_y       (s_axis_tdata[127:96]),
    .out_vld     (c_vld[0]),
    .out_side    (c_side[0]),
    .out_x       (c_x[0]),
    .out_z       (c_z[0])
  );

  assign c_y[0] = '0;

  // One cell per rotation step
  for (genvar i = 0; i < NS; i++) begin : g_cell
    rpr_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (pipe_en),
      .in_vld   (c_vld[i]),
      .in_side  (c_side[i]),
      .in_x     (c_x[i]),
      .in_y     (c_y[i]),
      .in_z     (c_z[i]),
      .out_vld  (c_vld[i+1]),
      .out_side (c_side[i+1]),
      .out_x    (c_x[i+1]),
      .out_y    (c_y[i+1]),
      .out_z    (c_z[i+1])
    );
  end

  // Rounding, offset and output buffering
  rpr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_vld      (c_vld[NS]),
    .in_side     (c_side[NS]),
    .in_x        (c_x[NS]),
    .in_y        (c_y[NS]),
    .en          (pipe_en),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .point_valid (res_pv),
    .point_x     (res_x),
    .point_y     (res_y)
  );

  assign s_axis_tready   = pipe_en;
  assign m_axis_tdata    = {res_y, res_x};
  assign m_axis_tuser[0] = res_pv;

endmodule
